### src/kaplan_meier_leaf_estimator_unit_assert.svh
// Assertion macros for the leaf estimator checker
`ifndef KAPLAN_MEIER_LEAF_ESTIMATOR_UNIT_ASSERT_SVH
`define KAPLAN_MEIER_LEAF_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define KM_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define KM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### src/kmle_pkg.sv
// Package: types and constants for the leaf estimator
`default_nettype none
package kmle_pkg;
    localparam int MAX_OBS_DEF = 64;
    localparam int TW = 32;
    localparam int WW = 8;
    localparam int TAGW = 10;
    localparam int SUMW = 14;
    localparam int SW = 31;
    localparam int HW = 31;
    localparam int NUMW = SW + SUMW;
    localparam int IN_DW = 56;
    localparam int OUT_DW = 104;
    localparam logic [SW-1:0] SURV_ONE = 31'h4000_0000;
    localparam logic [HW-1:0] HAZ_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        S_LOAD, S_RD, S_ACC, S_MUL, S_DIVS, S_DIVH, S_EMIT, S_FIN
    } t_state;
endpackage
`default_nettype wire

### src/kaplan_meier_leaf_estimator_unit.sv
// Leaf estimator top level: observation memory, group scan, divide sequencer
// Load: one observation per cycle in the load state, stored in a synchronous
// memory with one write and one read port. Curve: the scan reads each stored
// observation and checks each group boundary, then one multiply per group and,
// per event group, two restoring divides (survival, hazard) and one emit.
// Reset clears counters, sequencer and output valid; memory is not cleared.
`default_nettype none
module kaplan_meier_leaf_estimator_unit #(
    parameter int MAX_OBS = kmle_pkg::MAX_OBS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // leaf_tag[9:0], obs_time[41:10], obs_weight[49:42], zero pad
    input  wire logic [kmle_pkg::IN_DW-1:0]  s_tdata,
    // event_flag
    input  wire logic                        s_tuser,
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // out_leaf_tag[9:0], step_time[41:10], survival[72:42], cum_hazard[103:73]
    output logic [kmle_pkg::OUT_DW-1:0]      m_tdata,
    output logic                             m_tlast
);
    import kmle_pkg::*;

    localparam int AW = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
    localparam int CW = $clog2(MAX_OBS + 1);
    localparam int DCW = $clog2(NUMW);
    localparam int MW = TW + 1 + WW;

    logic [MW-1:0] mem [MAX_OBS];
    logic [MW-1:0] r_rdata;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, r_p, n_p;
    logic [SUMW-1:0] r_total, n_total, r_risk, n_risk, r_sub, n_sub, r_ev, n_ev;
    logic [SUMW-1:0] r_den, n_den;
    logic [TAGW-1:0] r_tag, n_tag;
    logic [TW-1:0] r_last_t, n_last_t, r_t, n_t;
    logic r_open, n_open, r_end, n_end;
    logic [NUMW-1:0] r_num, n_num;
    logic [SUMW:0] r_rem, n_rem;
    logic [DCW-1:0] r_dc, n_dc;
    logic [SW-1:0] r_surv, n_surv, r_ps, n_ps;
    logic [HW-1:0] r_haz, n_haz, r_ph, n_ph;
    logic [TW-1:0] r_pt, n_pt;
    logic r_pend, n_pend;
    logic r_ov, n_ov, r_olast, n_olast;
    logic [TW-1:0] r_ot, n_ot;
    logic [SW-1:0] r_os, n_os;
    logic [HW-1:0] r_oh, n_oh;
    logic [TAGW-1:0] r_otag, n_otag;

    logic in_xfer, out_free, do_store;
    logic [TW-1:0] in_time, rd_time;
    logic [WW-1:0] in_w, rd_w;
    logic rd_f;
    logic [SUMW:0] sh_rem;
    logic [SUMW:0] sub_rem;
    logic [HW:0] haz_sum;

    assign in_time = s_tdata[TAGW +: TW];
    assign in_w = s_tdata[TAGW+TW +: WW];
    assign rd_time = r_rdata[MW-1 -: TW];
    assign rd_f = r_rdata[WW];
    assign rd_w = r_rdata[WW-1:0];
    assign s_tready = (r_state == S_LOAD);
    assign in_xfer = s_tvalid && s_tready;
    assign do_store = in_xfer && (r_cnt < CW'(MAX_OBS));
    assign out_free = !r_ov || m_tready;

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            mem[r_cnt[AW-1:0]] <= {in_time, s_tuser, in_w};
        end
        r_rdata <= mem[r_p[AW-1:0]];
    end

    // restoring divide step
    assign sh_rem = {r_rem[SUMW-1:0], r_num[NUMW-1]};
    assign sub_rem = sh_rem - {1'b0, r_den};
    assign haz_sum = {1'b0, r_haz} + {1'b0, r_num[HW-1:0]};

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_p = r_p; n_total = r_total;
        n_risk = r_risk; n_sub = r_sub; n_ev = r_ev; n_den = r_den;
        n_tag = r_tag; n_last_t = r_last_t; n_t = r_t; n_open = r_open;
        n_end = r_end; n_num = r_num; n_rem = r_rem; n_dc = r_dc;
        n_surv = r_surv; n_haz = r_haz; n_ps = r_ps; n_ph = r_ph; n_pt = r_pt;
        n_pend = r_pend; n_ov = r_ov && !m_tready; n_olast = r_olast;
        n_ot = r_ot; n_os = r_os; n_oh = r_oh; n_otag = r_otag;
        case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    n_tag = s_tdata[TAGW-1:0];
                    if (do_store) begin
                        n_cnt = r_cnt + 1'b1;
                        n_total = r_total + SUMW'(in_w);
                        n_last_t = in_time;
                    end
                    if (s_tlast) begin
                        n_risk = do_store ? r_total + SUMW'(in_w) : r_total;
                        n_surv = SURV_ONE;
                        n_haz = '0;
                        n_p = '0;
                        n_open = 1'b0;
                        n_pend = 1'b0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_ACC;
            S_ACC: begin
                if (!r_open || rd_time == r_t) begin
                    n_open = 1'b1;
                    n_t = rd_time;
                    n_sub = (r_open ? r_sub : '0) + SUMW'(rd_w);
                    n_ev = (r_open ? r_ev : '0) + (rd_f ? SUMW'(rd_w) : '0);
                    n_p = r_p + 1'b1;
                    n_end = (n_p == r_cnt);
                    n_state = n_end ? S_MUL : S_RD;
                end else begin
                    n_end = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_den = r_risk;
                n_num = r_surv * (r_risk - r_ev);
                n_risk = (r_risk >= r_sub) ? r_risk - r_sub : '0;
                n_open = 1'b0;
                n_rem = '0;
                n_dc = '0;
                if (r_ev != '0 && r_risk >= r_ev) begin
                    n_state = S_DIVS;
                end else begin
                    n_state = r_end ? S_FIN : S_RD;
                end
            end
            S_DIVS, S_DIVH: begin
                if (!sub_rem[SUMW]) begin
                    n_rem = sub_rem;
                end else begin
                    n_rem = sh_rem;
                end
                n_num = {r_num[NUMW-2:0], !sub_rem[SUMW]};
                n_dc = r_dc + 1'b1;
                if (r_dc == DCW'(NUMW - 1)) begin
                    n_dc = '0;
                    n_rem = '0;
                    if (r_state == S_DIVS) begin
                        n_surv = n_num[SW-1:0];
                        n_num = {{(NUMW-SUMW-24){1'b0}}, r_ev, 24'd0};
                        n_state = S_DIVH;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                // r_num holds the hazard increment
                if (!r_pend || out_free) begin
                    if (r_pend) begin
                        n_ov = 1'b1; n_olast = 1'b0;
                        n_ot = r_pt; n_os = r_ps; n_oh = r_ph; n_otag = r_tag;
                    end
                    n_haz = haz_sum[HW] ? HAZ_MAX : haz_sum[HW-1:0];
                    n_pend = 1'b1;
                    n_pt = r_t; n_ps = r_surv; n_ph = n_haz;
                    n_state = r_end ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov = 1'b1; n_olast = 1'b1;
                    n_ot = r_pend ? r_pt : r_last_t;
                    n_os = r_pend ? r_ps : SURV_ONE;
                    n_oh = r_pend ? r_ph : '0;
                    n_otag = r_tag;
                    n_pend = 1'b0;
                    n_cnt = '0;
                    n_total = '0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_cnt <= '0; r_total <= '0; r_tag <= '0;
            r_pend <= 1'b0; r_ov <= 1'b0; r_p <= '0; r_dc <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_total <= n_total; r_tag <= n_tag;
            r_pend <= n_pend; r_ov <= n_ov; r_p <= n_p; r_dc <= n_dc;
        end
        r_risk <= n_risk; r_sub <= n_sub; r_ev <= n_ev; r_den <= n_den;
        r_last_t <= n_last_t; r_t <= n_t; r_open <= n_open; r_end <= n_end;
        r_num <= n_num; r_rem <= n_rem; r_surv <= n_surv; r_haz <= n_haz;
        r_ps <= n_ps; r_ph <= n_ph; r_pt <= n_pt; r_olast <= n_olast;
        r_ot <= n_ot; r_os <= n_os; r_oh <= n_oh; r_otag <= n_otag;
    end

    assign m_tvalid = r_ov;
    assign m_tlast = r_olast;
    assign m_tdata = {r_oh, r_os, r_ot, r_otag};
endmodule
`default_nettype wire

### src/kmle_checker.sv
// Port-level checker for the leaf estimator and its bind
`default_nettype none
`include "kaplan_meier_leaf_estimator_unit_assert.svh"
module kmle_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        s_tlast,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [kmle_pkg::OUT_DW-1:0] m_tdata
);
    import kmle_pkg::*;

    `KM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `KM_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, s_tvalid && s_tready && s_tlast, !s_tready)
    `KM_ASSERT_NOW(a_surv_range, i_clk, i_rst_n, m_tvalid, m_tdata[72:42] <= SURV_ONE)
endmodule

bind kaplan_meier_leaf_estimator_unit kmle_checker u_kmle_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

### verif/kaplan_meier_leaf_estimator_unit_tb.sv
// Self-checking testbench for the leaf survival estimator: stream stimulus, scoreboard
`default_nettype none
module kaplan_meier_leaf_estimator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kmle_pkg::*;

    typedef struct packed {
        logic [TAGW-1:0] tag;
        logic [TW-1:0]   t;
        logic            ev;
        logic [WW-1:0]   w;
        logic            last;
    } t_obs;

    typedef struct packed {
        logic [TAGW-1:0] tag;
        logic [TW-1:0]   t;
        logic [SW-1:0]   surv;
        logic [HW-1:0]   haz;
        logic            last;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic m_tlast;

    kaplan_meier_leaf_estimator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_obs  pending_obs[$];
    t_step expected_steps[$];
    int    send_idle_pct = 0, recv_idle_pct = 0;
    bit    hold_send = 1'b0;
    bit    in_taken = 1'b0;
    int    errors = 0, n_obs = 0, n_steps = 0, n_leaves = 0;
    longint cycles = 0;

    // predictor state
    logic [TW-1:0] km_time[MAX_OBS_DEF];
    logic          km_flag[MAX_OBS_DEF];
    logic [WW-1:0] km_wt[MAX_OBS_DEF];
    int unsigned   km_count = 0;
    logic [SUMW-1:0] km_total = '0;
    logic [TAGW-1:0] km_tag = '0;

    task automatic predict_curve();
        int unsigned p, k;
        logic [TW-1:0] t;
        longint unsigned risk, surv, haz, sub, ev;
        t_step s;
        p = 0; k = 0;
        risk = km_total; surv = SURV_ONE; haz = 0;
        while (p < km_count) begin
            t = km_time[p]; sub = 0; ev = 0;
            while (p < km_count && km_time[p] == t) begin
                sub += km_wt[p];
                if (km_flag[p]) ev += km_wt[p];
                p++;
            end
            if (ev > 0 && risk >= ev && k < MAX_OBS_DEF) begin
                surv = (surv * (risk - ev)) / risk;
                haz += (ev << 24) / risk;
                if (haz > HAZ_MAX) haz = HAZ_MAX;
                s.tag = km_tag; s.t = t; s.surv = surv[SW-1:0];
                s.haz = haz[HW-1:0]; s.last = 1'b0;
                expected_steps.push_back(s);
                k++;
            end
            risk = (risk >= sub) ? risk - sub : 0;
        end
        if (k == 0) begin
            s.tag = km_tag; s.t = (km_count > 0) ? km_time[km_count-1] : '0;
            s.surv = SURV_ONE; s.haz = '0; s.last = 1'b0;
            expected_steps.push_back(s);
        end
        expected_steps[$].last = 1'b1;
    endtask

    task automatic predict_obs(input t_obs o);
        km_tag = o.tag;
        if (km_count < MAX_OBS_DEF) begin
            km_time[km_count] = o.t; km_flag[km_count] = o.ev; km_wt[km_count] = o.w;
            km_total = km_total + SUMW'(o.w);
            km_count++;
        end
        if (o.last) begin
            predict_curve();
            km_count = 0; km_total = '0;
            n_leaves++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && !in_taken) begin
                // hold current transfer
            end else if (pending_obs.size() > 0 && !hold_send &&
                         $urandom_range(99) >= send_idle_pct) begin
                t_obs o;
                o = pending_obs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, o.w, o.t, o.tag};
                s_tuser  <= o.ev;
                s_tlast  <= o.last;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        in_taken = i_rst_n && s_tvalid && s_tready;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                t_obs o;
                o.tag = s_tdata[9:0]; o.t = s_tdata[41:10]; o.w = s_tdata[49:42];
                o.ev = s_tuser; o.last = s_tlast;
                predict_obs(o);
                n_obs++;
            end
            if (m_tvalid && m_tready) begin
                t_step got, exp_s;
                got.tag = m_tdata[9:0]; got.t = m_tdata[41:10];
                got.surv = m_tdata[72:42]; got.haz = m_tdata[103:73]; got.last = m_tlast;
                n_steps++;
                if (expected_steps.size() == 0) begin
                    $display("%0t: unexpected step %h", $realtime, got);
                    errors++;
                end else begin
                    exp_s = expected_steps.pop_front();
                    if (got.tag !== exp_s.tag)
                        $display("%0t: tag exp %h got %h", $realtime, exp_s.tag, got.tag);
                    if (got.t !== exp_s.t)
                        $display("%0t: time exp %h got %h", $realtime, exp_s.t, got.t);
                    if (got.surv !== exp_s.surv)
                        $display("%0t: surv exp %h got %h", $realtime, exp_s.surv, got.surv);
                    if (got.haz !== exp_s.haz)
                        $display("%0t: haz exp %h got %h", $realtime, exp_s.haz, got.haz);
                    if (got.last !== exp_s.last)
                        $display("%0t: last exp %b got %b", $realtime, exp_s.last, got.last);
                    if (got !== exp_s) errors++;
                end
            end
        end
        if (cycles > 2000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // n observations, ascending unless mode 3, some ties, mostly events unless mode 1
    task automatic add_leaf(input int n, input int mode);
        logic [TAGW-1:0] tag;
        logic [TW-1:0] t;
        t_obs o;
        tag = 10'($urandom);
        t = (mode == 2) ? 32'hFFFF_FF00 : $urandom_range(1000);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) != 0) t = t + $urandom_range(1, 50);
            if (mode == 3) t = $urandom; // unsorted noise
            o.tag = (mode == 3) ? 10'($urandom) : tag;
            o.t = t;
            o.ev = (mode == 1) ? 1'b0 : ($urandom_range(2) != 0);
            o.w = ($urandom_range(9) == 0) ? 8'd0 :
                  ($urandom_range(4) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
            o.last = (i == n - 1);
            pending_obs.push_back(o);
        end
    endtask

    task automatic drain();
        int c;
        c = 0;
        while ((pending_obs.size() > 0 || s_tvalid || expected_steps.size() > 0) && c < 500000) begin
            @(posedge i_clk); c++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        t_obs o;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: single obs leaf, extremes
        o = '{tag: 10'h3FF, t: 32'hFFFF_FFFF, ev: 1'b1, w: 8'd255, last: 1'b1};
        pending_obs.push_back(o);
        o = '{tag: 10'h000, t: 32'h0, ev: 1'b1, w: 8'd0, last: 1'b1}; // weight-zero event
        pending_obs.push_back(o);
        o = '{tag: 10'h155, t: 32'd5, ev: 1'b0, w: 8'd1, last: 1'b0};
        pending_obs.push_back(o);
        o = '{tag: 10'h2AA, t: 32'd5, ev: 1'b1, w: 8'd1, last: 1'b1}; // tie
        pending_obs.push_back(o);
        add_leaf(3, 1);        // no events
        add_leaf(4, 2);        // high times
        add_leaf(6, 3);        // unsorted
        send_idle_pct = 18; recv_idle_pct = 63;
        // overfull store: 70 items
        for (int i = 0; i < 70; i++) begin
            o = '{tag: 10'($urandom), t: 32'(i / 2), ev: 1'b1, w: 8'd255, last: (i == 69)};
            pending_obs.push_back(o);
        end
        drain();

        for (int i = 0; i < 7; i++) add_leaf($urandom_range(1, 8), $urandom_range(9) == 0 ? 3 : 0);
        drain();
        hold_send = 1'b1;
        send_idle_pct = 63; recv_idle_pct = 18;
        drain();
        hold_send = 1'b0;
        for (int i = 0; i < 7; i++) add_leaf($urandom_range(1, 8), $urandom_range(5) == 0 ? 1 : 0);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 6; i++) add_leaf($urandom_range(1, 8), 0);
        drain();

        $display("Covered %0d observations in %0d leaves, %0d curve steps checked.",
                 n_obs, n_leaves, n_steps);
        if (errors == 0 && expected_steps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
